@@ rtl/owas_posture_classifier_assert.svh @@
// assertion macros for the owas posture classifier
// used by the top level; needs nothing else
`ifndef OWAS_POSTURE_CLASSIFIER_ASSERT_SVH
`define OWAS_POSTURE_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OWAS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("owas assertion failed");

// next-cycle implication, checked out of reset
`define OWAS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("owas assertion failed");

`endif

@@ rtl/owas_pkg.sv @@
// shared types, constants and the action table for the owas posture classifier
// no dependencies
package owas_pkg;

    localparam int OWAS_NODE_COUNT = 8;
    localparam int MARK_COUNT      = 7;
    localparam int MAG_W           = 8;
    localparam int ANGLE_W         = 9;
    localparam int NODE_W          = 3;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 8;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 16;

    localparam logic [MARK_COUNT-1:0] ALL_MARKS = '1;

    // node ids
    localparam logic [NODE_W-1:0] NODE_NONE      = 3'd0;
    localparam logic [NODE_W-1:0] NODE_BACK      = 3'd1;
    localparam logic [NODE_W-1:0] NODE_RIGHT_ARM = 3'd2;
    localparam logic [NODE_W-1:0] NODE_LEFT_ARM  = 3'd3;
    localparam logic [NODE_W-1:0] NODE_RIGHT_LEG = 3'd4;
    localparam logic [NODE_W-1:0] NODE_LEFT_LEG  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ARMS_LIMIT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_ROLL_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_PITCH_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEG_BENT_BOUND   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEG_SIT_BOUND    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEG_SQUAT_BOUND  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEG_MOVE_LIMIT   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_USER_LOAD        = 3'd7;

    // fixed thresholds
    localparam logic [MAG_W-1:0] LOAD_LOW  = 8'd10;
    localparam logic [MAG_W-1:0] LOAD_HIGH = 8'd20;
    localparam logic [MAG_W-1:0] LEG_MAX   = 8'd180;

    typedef struct packed {
        logic [MAG_W-1:0] arms_limit;
        logic [MAG_W-1:0] back_roll_limit;
        logic [MAG_W-1:0] back_pitch_limit;
        logic [MAG_W-1:0] leg_bent_bound;
        logic [MAG_W-1:0] leg_sit_bound;
        logic [MAG_W-1:0] leg_squat_bound;
        logic [MAG_W-1:0] leg_move_limit;
        logic [MAG_W-1:0] user_load;
    } cfg_t;

    // stored magnitudes the classifier looks at
    typedef struct packed {
        logic [MAG_W-1:0] back_roll;
        logic [MAG_W-1:0] back_pitch;
        logic [MAG_W-1:0] rarm_roll;
        logic [MAG_W-1:0] rarm_pitch;
        logic [MAG_W-1:0] larm_roll;
        logic [MAG_W-1:0] larm_pitch;
        logic [MAG_W-1:0] rleg_angle;
        logic [MAG_W-1:0] lleg_angle;
        logic [MAG_W-1:0] rleg_move_roll;
        logic [MAG_W-1:0] rleg_move_pitch;
        logic [MAG_W-1:0] lleg_move_roll;
        logic [MAG_W-1:0] lleg_move_pitch;
    } posture_t;

    typedef struct packed {
        logic                  fire;
        logic [MARK_COUNT-1:0] marks;
    } stage_status_t;

    // last member sits in the lowest bits, matching the output beat layout
    typedef struct packed {
        logic       warning;
        logic [2:0] action_level;
        logic [1:0] load_code;
        logic [2:0] legs_code;
        logic [1:0] arms_code;
        logic [2:0] back_code;
    } result_t;

    // action table, one hex digit per column, column 0 in the top digit
    localparam logic [83:0] ACTION_ROWS [12] = '{
        84'h111_111_111_222_222_111_111,
        84'h111_111_111_222_222_111_111,
        84'h111_111_111_222_222_111_111,
        84'h223_223_223_333_333_222_233,
        84'h223_223_233_344_344_334_234,
        84'h334_223_333_344_444_444_234,
        84'h111_111_112_333_444_111_111,
        84'h223_111_112_444_444_333_111,
        84'h223_111_233_444_444_444_111,
        84'h233_223_223_444_444_444_234,
        84'h334_234_334_444_444_444_234,
        84'h444_234_334_444_444_444_234
    };

    function automatic logic [2:0] action_lookup(input logic [3:0] row, input logic [4:0] col);
        logic [83:0] bits;
        logic [4:0]  digit;
        logic [6:0]  sel;
        bits  = ACTION_ROWS[row];
        digit = 5'd20 - col;
        sel   = {digit, 2'b00};
        return bits[sel +: 3];
    endfunction

    // absolute value of a 9-bit signed field, -256 saturates to 255
    function automatic logic [MAG_W-1:0] mag9(input logic [ANGLE_W-1:0] v);
        logic [ANGLE_W-1:0] m;
        m = v[ANGLE_W-1] ? (~v + 9'd1) : v;
        return m[ANGLE_W-1] ? 8'hFF : m[MAG_W-1:0];
    endfunction

endpackage

@@ rtl/owas_input_stage.sv @@
// per-node magnitude stores and arrival marks for the owas posture classifier
// depends on owas_pkg
module owas_input_stage import owas_pkg::*; #(
    parameter int NODE_COUNT = OWAS_NODE_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 advance,
    input  logic [NODE_W-1:0]    node_id,
    input  logic [ANGLE_W-1:0]   roll_angle,
    input  logic [ANGLE_W-1:0]   pitch_angle,
    input  logic [ANGLE_W-1:0]   move_roll,
    input  logic [ANGLE_W-1:0]   move_pitch,
    output posture_t             posture,
    output stage_status_t        status
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [MAG_W-1:0] roll_store_reg       [NODE_COUNT];
    logic [MAG_W-1:0] pitch_store_reg      [NODE_COUNT];
    logic [MAG_W-1:0] move_roll_store_reg  [NODE_COUNT];
    logic [MAG_W-1:0] move_pitch_store_reg [NODE_COUNT];

    logic [MARK_COUNT-1:0] marks_reg, marks_next, marks_set;
    logic                  fire_reg, fire_next;
    logic                  write_en;
    logic [IDX_W-1:0]      idx;

    assign idx      = IDX_W'(node_id);
    assign write_en = accept && (node_id != NODE_NONE);

    // payload stores, no reset: entries are only read once written
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            roll_store_reg[idx]       <= mag9(roll_angle);
            pitch_store_reg[idx]      <= mag9(pitch_angle);
            move_roll_store_reg[idx]  <= mag9(move_roll);
            move_pitch_store_reg[idx] <= mag9(move_pitch);
        end
    end

    always_comb
    begin
        marks_set  = marks_reg | MARK_COUNT'(8'd1 << (node_id - 3'd1));
        marks_next = marks_reg;
        fire_next  = fire_reg && !advance;
        if (write_en)
        begin
            if (marks_set == ALL_MARKS)
            begin
                marks_next = '0;
                fire_next  = 1'b1;
            end
            else
            begin
                marks_next = marks_set;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
            fire_reg  <= 1'b0;
        end
        else
        begin
            marks_reg <= marks_next;
            fire_reg  <= fire_next;
        end
    end

    assign posture.back_roll       = roll_store_reg[IDX_W'(NODE_BACK)];
    assign posture.back_pitch      = pitch_store_reg[IDX_W'(NODE_BACK)];
    assign posture.rarm_roll       = roll_store_reg[IDX_W'(NODE_RIGHT_ARM)];
    assign posture.rarm_pitch      = pitch_store_reg[IDX_W'(NODE_RIGHT_ARM)];
    assign posture.larm_roll       = roll_store_reg[IDX_W'(NODE_LEFT_ARM)];
    assign posture.larm_pitch      = pitch_store_reg[IDX_W'(NODE_LEFT_ARM)];
    assign posture.rleg_angle      = roll_store_reg[IDX_W'(NODE_RIGHT_LEG)];
    assign posture.lleg_angle      = roll_store_reg[IDX_W'(NODE_LEFT_LEG)];
    assign posture.rleg_move_roll  = move_roll_store_reg[IDX_W'(NODE_RIGHT_LEG)];
    assign posture.rleg_move_pitch = move_pitch_store_reg[IDX_W'(NODE_RIGHT_LEG)];
    assign posture.lleg_move_roll  = move_roll_store_reg[IDX_W'(NODE_LEFT_LEG)];
    assign posture.lleg_move_pitch = move_pitch_store_reg[IDX_W'(NODE_LEFT_LEG)];

    assign status.fire  = fire_reg;
    assign status.marks = marks_reg;

endmodule

@@ rtl/owas_classify.sv @@
// combinational owas classification: back, arms, legs, load and action level
// depends on owas_pkg
module owas_classify import owas_pkg::*; (
    input  posture_t posture,
    input  cfg_t     cfg,
    output result_t  result
);

    logic       twisted, bent;
    logic       rarm_up, larm_up;
    logic       rmov, lmov;
    logic       r_low, r_bent_max, r_mid, r_sit_max, r_sit, r_squat;
    logic       l_low, l_bent_max, l_mid, l_sit_max, l_sit, l_squat;
    logic [2:0] back, legs;
    logic [1:0] arms, load;
    logic [2:0] level;
    logic [3:0] row, back_off;
    logic [4:0] col, legs_off;

    always_comb
    begin
        twisted = posture.back_roll > cfg.back_roll_limit;
        bent    = posture.back_pitch > cfg.back_pitch_limit;
        if (twisted && bent)
            back = 3'd4;
        else if (bent)
            back = 3'd3;
        else if (twisted)
            back = 3'd2;
        else
            back = 3'd1;

        rarm_up = (posture.rarm_roll > cfg.arms_limit) || (posture.rarm_pitch > cfg.arms_limit);
        larm_up = (posture.larm_roll > cfg.arms_limit) || (posture.larm_pitch > cfg.arms_limit);
        arms    = 2'd1 + 2'(rarm_up) + 2'(larm_up);

        rmov = (posture.rleg_move_roll > cfg.leg_move_limit)
            || (posture.rleg_move_pitch > cfg.leg_move_limit);
        lmov = (posture.lleg_move_roll > cfg.leg_move_limit)
            || (posture.lleg_move_pitch > cfg.leg_move_limit);

        // half-open ranges on the upper-leg angles
        r_low      = posture.rleg_angle < cfg.leg_bent_bound;
        r_bent_max = (posture.rleg_angle >= cfg.leg_bent_bound) && (posture.rleg_angle < LEG_MAX);
        r_mid      = (posture.rleg_angle >= cfg.leg_bent_bound)
            && (posture.rleg_angle < cfg.leg_sit_bound);
        r_sit_max  = (posture.rleg_angle >= cfg.leg_sit_bound) && (posture.rleg_angle < LEG_MAX);
        r_sit      = (posture.rleg_angle >= cfg.leg_sit_bound)
            && (posture.rleg_angle < cfg.leg_squat_bound);
        r_squat    = (posture.rleg_angle >= cfg.leg_squat_bound) && (posture.rleg_angle < LEG_MAX);

        l_low      = posture.lleg_angle < cfg.leg_bent_bound;
        l_bent_max = (posture.lleg_angle >= cfg.leg_bent_bound) && (posture.lleg_angle < LEG_MAX);
        l_mid      = (posture.lleg_angle >= cfg.leg_bent_bound)
            && (posture.lleg_angle < cfg.leg_sit_bound);
        l_sit_max  = (posture.lleg_angle >= cfg.leg_sit_bound) && (posture.lleg_angle < LEG_MAX);
        l_sit      = (posture.lleg_angle >= cfg.leg_sit_bound)
            && (posture.lleg_angle < cfg.leg_squat_bound);
        l_squat    = (posture.lleg_angle >= cfg.leg_squat_bound) && (posture.lleg_angle < LEG_MAX);

        if (rmov && lmov)
            legs = 3'd7;
        else if ((r_low && l_bent_max) || (r_bent_max && l_low))
            legs = 3'd3;
        else if (r_low && l_low)
            legs = 3'd2;
        else if ((r_mid && l_sit_max) || (r_sit_max && l_mid))
            legs = 3'd5;
        else if (r_mid && l_mid)
            legs = 3'd4;
        else if (r_sit && l_sit)
            legs = 3'd1;
        else if (r_squat && l_squat)
            legs = 3'd6;
        else
            legs = 3'd1;

        if (cfg.user_load >= LOAD_HIGH)
            load = 2'd3;
        else if (cfg.user_load >= LOAD_LOW)
            load = 2'd2;
        else
            load = 2'd1;

        back_off = 4'(back) - 4'd1;
        row      = back_off * 4'd3 + 4'(arms) - 4'd1;
        legs_off = 5'(legs) - 5'd1;
        col      = legs_off * 5'd3 + 5'(load) - 5'd1;
        level    = action_lookup(row, col);

        result.back_code    = back;
        result.arms_code    = arms;
        result.legs_code    = legs;
        result.load_code    = load;
        result.action_level = level;
        result.warning      = (level == 3'd4);
    end

endmodule

@@ rtl/owas_posture_classifier.sv @@
// top level of the owas posture classifier: config registers, output register
// depends on owas_pkg, owas_input_stage, owas_classify, owas_posture_classifier_assert.svh
//
// channel   dir  beat contents (lowest bits first)
// s_axis    in   node_id[3] roll_angle[9] pitch_angle[9] move_roll[9] move_pitch[9] pad[1]
// m_axis    out  back_code[3] arms_code[2] legs_code[3] load_code[2] action_level[3]
//                warning[1] pad[2]
// cfg       in   write enable, register index, 8-bit data, write only
//
// one input beat per cycle while s_tready is high; the magnitudes are stored at the
// accepting edge, and a completing beat (all of nodes 1 to 7 seen) sets the pending flag
// and its result is loaded into the output register once that register frees
// s_tready drops only while a finished result waits behind a full, stalled
// output register; the single fire flag in the input stage sets that limit
// reset clears the arrival marks, the pending flag, the output valid and the
// config registers to defaults; the magnitude stores and result register are not cleared
`include "owas_posture_classifier_assert.svh"

module owas_posture_classifier import owas_pkg::*; #(
    parameter int NODE_COUNT = OWAS_NODE_COUNT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // node_id, roll_angle, pitch_angle, move_roll, move_pitch, zero pad
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // back_code, arms_code, legs_code, load_code, action_level, warning, zero pad
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t          cfg_reg, cfg_next;
    posture_t      posture;
    stage_status_t status;
    result_t       result, result_reg;
    logic          out_valid_reg, out_valid_next;
    logic          advance;
    logic          s_accept;

    // input beat fields
    logic [NODE_W-1:0]  node_id;
    logic [ANGLE_W-1:0] roll_angle, pitch_angle, move_roll, move_pitch;

    assign node_id     = s_tdata[2:0];
    assign roll_angle  = s_tdata[11:3];
    assign pitch_angle = s_tdata[20:12];
    assign move_roll   = s_tdata[29:21];
    assign move_pitch  = s_tdata[38:30];

    // output register frees when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !status.fire || advance;
    assign s_accept = s_tvalid && s_tready;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ARMS_LIMIT:       cfg_next.arms_limit       = cfg_data;
                CFG_BACK_ROLL_LIMIT:  cfg_next.back_roll_limit  = cfg_data;
                CFG_BACK_PITCH_LIMIT: cfg_next.back_pitch_limit = cfg_data;
                CFG_LEG_BENT_BOUND:   cfg_next.leg_bent_bound   = cfg_data;
                CFG_LEG_SIT_BOUND:    cfg_next.leg_sit_bound    = cfg_data;
                CFG_LEG_SQUAT_BOUND:  cfg_next.leg_squat_bound  = cfg_data;
                CFG_LEG_MOVE_LIMIT:   cfg_next.leg_move_limit   = cfg_data;
                CFG_USER_LOAD:        cfg_next.user_load        = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arms_limit       <= 8'd90;
            cfg_reg.back_roll_limit  <= 8'd20;
            cfg_reg.back_pitch_limit <= 8'd20;
            cfg_reg.leg_bent_bound   <= 8'd20;
            cfg_reg.leg_sit_bound    <= 8'd60;
            cfg_reg.leg_squat_bound  <= 8'd120;
            cfg_reg.leg_move_limit   <= 8'd130;
            cfg_reg.user_load        <= 8'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // magnitude stores, arrival marks and the pending-result flag
    owas_input_stage #(
        .NODE_COUNT (NODE_COUNT)
    ) u_input_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .advance     (advance),
        .node_id     (node_id),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .move_roll   (move_roll),
        .move_pitch  (move_pitch),
        .posture     (posture),
        .status      (status)
    );

    // classification from the stored magnitudes
    owas_classify u_classify (
        .posture (posture),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // output register: loads when a result is pending and the slot frees
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = status.fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && status.fire)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

    // a pending result always follows a clearing of the marks
    `OWAS_ASSERT_NOW(a_fire_marks_clear, clk, rst_n, status.fire, status.marks == '0)
    // node zero beats leave the marks untouched
    `OWAS_ASSERT_NEXT(a_node_zero_ignored, clk, rst_n, s_accept && (node_id == NODE_NONE),
        $stable(status.marks))
    // a pending result blocked by a stalled output holds off new beats
    `OWAS_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, status.fire && out_valid_reg && !m_tready,
        !s_tready)

endmodule
